/* design/rcfc_pkg.sv */
// Shared types, constants and helpers for the rolling code frame codec.
package rcfc_pkg;

  localparam int unsigned FrameW  = 56;
  localparam int unsigned SerialW = 24;
  localparam int unsigned ButtonW = 4;
  localparam int unsigned CountW  = 16;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned NumBytes = FrameW / 8;

  localparam logic [KeyW-1:0] KeyReset = 8'hA7;

  typedef enum logic {
    CmdGenerate = 1'b0,
    CmdDecode   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [SerialW-1:0] serial;
    logic [ButtonW-1:0] button;
    logic [CountW-1:0]  counter;
    logic [FrameW-1:0]  frame;
  } item_t;

  typedef struct packed {
    logic [FrameW-1:0]  frame;
    logic [ButtonW-1:0] button;
    logic [CountW-1:0]  counter;
    logic [SerialW-1:0] serial;
    logic               checksum_ok;
  } result_t;

  // XOR of both nibbles of every byte
  function automatic logic [3:0] nibble_fold(input logic [FrameW-1:0] frame);
    logic [3:0] acc;
    acc = 4'h0;
    for (int k = 0; k < NumBytes; k++) begin
      acc = acc ^ frame[8*k +: 4] ^ frame[8*k+4 +: 4];
    end
    return acc;
  endfunction

endpackage

/* design/rolling_code_frame_codec_top.sv */
// Top level of the rolling code frame codec: input register, codec logic, result register.
//
// Takes one transaction per clock (busy_o stays low) and returns its result through the
// input register and the result register, for one cycle marked by valid_o; the receiver
// cannot stall, so no buffering beyond the result register is needed. These registers
// surround the combinational XOR and packing logic. cmd 0 builds an obfuscated frame from
// serial, button, counter and key_byte; cmd 1 undoes the obfuscation of frame_in and
// reports the fields and the nibble checksum. key_byte resets to 0xA7 and is written
// through the cfg channel; the user must write it only while idle, which is not enforced.
module rolling_code_frame_codec_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           cmd_i,
  input  logic [rcfc_pkg::SerialW-1:0]   serial_in_i,
  input  logic [rcfc_pkg::ButtonW-1:0]   button_in_i,
  input  logic [rcfc_pkg::CountW-1:0]    counter_in_i,
  input  logic [rcfc_pkg::FrameW-1:0]    frame_in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rcfc_pkg::KeyW-1:0]      cfg_data_i,
  output logic                           valid_o,
  output logic [rcfc_pkg::FrameW-1:0]    frame_out_o,
  output logic [rcfc_pkg::ButtonW-1:0]   button_out_o,
  output logic [rcfc_pkg::CountW-1:0]    counter_out_o,
  output logic [rcfc_pkg::SerialW-1:0]   serial_out_o,
  output logic                           checksum_ok_o
);

  logic                        accept;
  logic [rcfc_pkg::KeyW-1:0]   key_q;
  logic                        in_vld_q;
  rcfc_pkg::item_t             item_q;
  rcfc_pkg::item_t             item_d;
  rcfc_pkg::result_t           res_d;
  rcfc_pkg::result_t           res_q;
  logic                        out_vld_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  assign item_d.cmd     = rcfc_pkg::cmd_e'(cmd_i);
  assign item_d.serial  = serial_in_i;
  assign item_d.button  = button_in_i;
  assign item_d.counter = counter_in_i;
  assign item_d.frame   = frame_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= rcfc_pkg::KeyReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        key_q <= cfg_data_i;
      end
      in_vld_q  <= accept;
      out_vld_q <= in_vld_q;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  rcfc_core u_core (
    .item_i     (item_q),
    .key_byte_i (key_q),
    .result_o   (res_d)
  );

  assign valid_o       = out_vld_q;
  assign frame_out_o   = res_q.frame;
  assign button_out_o  = res_q.button;
  assign counter_out_o = res_q.counter;
  assign serial_out_o  = res_q.serial;
  assign checksum_ok_o = res_q.checksum_ok;

  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result strobe without an accepted transaction two cycles earlier");

  a_no_result_without_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> valid_o)
    else $error("accepted transaction dropped before the result register");

  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && checksum_ok_o) |-> (frame_out_o == '0))
    else $error("decode result carries a generated frame");

endmodule

/* design/rcfc_core.sv */
// Combinational frame builder and frame checker for one transaction.
module rcfc_core (
  input  rcfc_pkg::item_t              item_i,
  input  logic [rcfc_pkg::KeyW-1:0]    key_byte_i,
  output rcfc_pkg::result_t            result_o
);

  logic [rcfc_pkg::FrameW-1:0] plain_gen;
  logic [rcfc_pkg::FrameW-1:0] enc_gen;
  logic [rcfc_pkg::FrameW-1:0] plain_dec;
  logic [3:0]                  gen_sum;

  always_comb begin
    plain_gen = {key_byte_i, item_i.button, 4'h0, item_i.counter, item_i.serial};
    gen_sum   = rcfc_pkg::nibble_fold(plain_gen);
    plain_gen[43:40] = gen_sum;
    // keep the top byte, then chain each lower byte with the previous obfuscated byte
    enc_gen[rcfc_pkg::FrameW-1 -: 8] = plain_gen[rcfc_pkg::FrameW-1 -: 8];
    for (int k = rcfc_pkg::NumBytes - 2; k >= 0; k--) begin
      enc_gen[8*k +: 8] = plain_gen[8*k +: 8] ^ enc_gen[8*(k+1) +: 8];
    end
  end

  assign plain_dec = item_i.frame ^ {8'h00, item_i.frame[rcfc_pkg::FrameW-1:8]};

  always_comb begin
    result_o = '0;
    unique case (item_i.cmd)
      rcfc_pkg::CmdGenerate: begin
        result_o.frame = enc_gen;
      end
      rcfc_pkg::CmdDecode: begin
        result_o.button      = plain_dec[47:44];
        result_o.counter     = plain_dec[39:24];
        result_o.serial      = plain_dec[23:0];
        result_o.checksum_ok = (rcfc_pkg::nibble_fold(plain_dec) == 4'h0);
      end
      default: result_o = '0;
    endcase
  end

endmodule
